// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// clocked assertion with asynchronous reset disable
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// two signal implication in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ===== rtl/bchs_pkg.sv =====
// types, constants and gf(2^15) helpers for the bch syndrome block
`timescale 1ns / 1ps
package bchs_pkg;
	localparam int MaxCodewordBytes = 4096;
	localparam int NumSyndromes     = 24;
	localparam int SymW             = 15;
	localparam int LenW             = 13;
	localparam int CntW             = 5;
	localparam int IdxW             = 5;
	localparam int CfgIdxW          = 4;

	typedef logic [SymW-1:0] sym_t;
	typedef sym_t col_t [SymW];

	typedef enum logic [CfgIdxW-1:0] {
		REG_CODEWORD_BYTES = 4'd0,
		REG_SYNDROME_COUNT = 4'd1
	} cfg_reg_t;

	localparam sym_t GEN_LOW [NumSyndromes] = '{
		15'h0003, 15'h0003, 15'h0423, 15'h0003, 15'h100B, 15'h0423, 15'h2AAB, 15'h0003,
		15'h0437, 15'h100B, 15'h08C7, 15'h0423, 15'h00CF, 15'h2AAB, 15'h7FFD, 15'h0003,
		15'h0729, 15'h0437, 15'h103D, 15'h100B, 15'h2FC1, 15'h08C7, 15'h0431, 15'h0423
	};

	// shift the top nbits of d into r, msb first, lfsr feedback g
	function automatic sym_t shift_in(sym_t r, sym_t g, logic [7:0] d, int nbits);
		sym_t x;
		logic fb;
		x = r;
		for (int i = 0; i < 8; i++) begin
			if (i < nbits) begin
				fb = x[SymW-1] ^ d[7-i];
				x  = {x[SymW-2:0], 1'b0};
				if (fb) x = x ^ g;
			end
		end
		return x;
	endfunction

	// alpha^n with field polynomial x^15 + x + 1
	function automatic sym_t gf_pow(int n);
		logic [SymW:0] a;
		a = 16'h0001;
		for (int i = 0; i < n; i++) begin
			a = {a[SymW-1:0], 1'b0};
			if (a[SymW]) a = a ^ 16'h8003;
		end
		return a[SymW-1:0];
	endfunction

	// columns of the evaluation matrix at alpha^(k+1)
	function automatic col_t eval_cols(int k);
		col_t c;
		for (int j = 0; j < SymW; j++) c[j] = gf_pow((k + 1) * j);
		return c;
	endfunction
endpackage

// ===== rtl/bchs_if.sv =====
// handshake interfaces for bytes in, syndromes out and configuration writes
`timescale 1ns / 1ps
interface bchs_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

interface bchs_syn_if;
	logic        valid;
	logic        ready;
	logic [4:0]  syndrome_index;
	logic [14:0] syndrome_value;
	logic        last_syndrome;
	modport source (output valid, output syndrome_index, output syndrome_value,
		output last_syndrome, input ready);
	modport sink (input valid, input syndrome_index, input syndrome_value,
		input last_syndrome, output ready);
endinterface

interface bchs_cfg_if;
	logic        valid;
	logic        ready;
	logic [3:0]  index;
	logic [12:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/bch_syndrome_gf2_15.sv =====
// top level: byte-serial bch syndrome calculator over gf(2^15)
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Takes one codeword byte per cycle, msb first, while din.ready is high,
// and keeps 24 15-bit lfsr remainders updated by fixed xor logic. The
// last three bytes of a codeword follow the tail rule (five bits
// shifted plus a direct xor, one byte held, then a nibble fold). On the last
// byte the finished remainders move into a snapshot bank and the working bank
// clears, so the next codeword streams in at once. The snapshot drains one
// syndrome per cycle, while dout.ready allows, through an output register,
// syndrome_count syndromes per codeword (1 to 24); the only input stall is
// a last byte while the previous snapshot drains. codeword_bytes (index 0) and
// syndrome_count (index 1) are clamped to 3..4096 and 1..24; write them only
// while the block is idle. No clearing pass after reset.
module bch_syndrome_gf2_15 (
	input  logic clk,
	input  logic arst_n,
	bchs_byte_if.sink  din,
	bchs_syn_if.source dout,
	bchs_cfg_if.sink   cfg
);
	import bchs_pkg::*;

	// configuration registers
	logic [LenW-1:0] codeword_bytes_q;
	logic [CntW-1:0] syndrome_count_q;

	// working bank
	sym_t            rem_q [NumSyndromes];
	logic [LenW-1:0] pos_q;
	logic [7:0]      held_q;

	// snapshot bank and emitter
	sym_t            snap_q [NumSyndromes];
	logic [CntW-1:0] snap_cnt_q;
	logic            busy_q;
	logic [IdxW-1:0] emit_idx_q;

	// output register
	logic            out_valid_q;
	logic [IdxW-1:0] out_idx_q;
	sym_t            out_val_q;
	logic            out_last_q;

	logic [LenW-1:0] len_c;
	logic [LenW-1:0] len_m3;
	logic [CntW-1:0] cnt_c;
	logic            is_body, is_tail, is_hold, is_last;
	logic            in_fire, snap_load, out_load;
	sym_t            syn_w [NumSyndromes];

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codeword_bytes_q <= LenW'(MaxCodewordBytes);
			syndrome_count_q <= CntW'(NumSyndromes);
		end else if (cfg.valid) begin
			if (cfg.index == REG_CODEWORD_BYTES) codeword_bytes_q <= cfg.data;
			else if (cfg.index == REG_SYNDROME_COUNT) syndrome_count_q <= cfg.data[CntW-1:0];
		end
	end

	// clamp length and count to their legal ranges
	always_comb begin
		priority if (codeword_bytes_q < LenW'(3)) len_c = LenW'(3);
		else if (codeword_bytes_q > LenW'(MaxCodewordBytes)) len_c = LenW'(MaxCodewordBytes);
		else len_c = codeword_bytes_q;
		priority if (syndrome_count_q == '0) cnt_c = CntW'(1);
		else if (syndrome_count_q > CntW'(NumSyndromes)) cnt_c = CntW'(NumSyndromes);
		else cnt_c = syndrome_count_q;
	end

	// position decode; past the end counts as the last byte
	assign len_m3  = len_c - LenW'(3);
	assign is_body = pos_q < len_m3;
	assign is_tail = pos_q == len_m3;
	assign is_hold = pos_q == len_m3 + LenW'(1);
	assign is_last = !is_body && !is_tail && !is_hold;

	// a last byte waits for a free snapshot bank
	assign din.ready = !(is_last && busy_q);
	assign in_fire   = din.valid && din.ready;
	assign snap_load = in_fire && is_last;
	assign out_load  = busy_q && (!out_valid_q || dout.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			held_q <= '0;
			for (int k = 0; k < NumSyndromes; k++) rem_q[k] <= '0;
		end else if (in_fire) begin
			if (is_last) begin
				pos_q  <= '0;
				held_q <= '0;
				for (int k = 0; k < NumSyndromes; k++) rem_q[k] <= '0;
			end else begin
				pos_q <= pos_q + LenW'(1);
				if (is_hold) held_q <= din.data_byte;
				for (int k = 0; k < NumSyndromes; k++) begin
					if (is_body) begin
						rem_q[k] <= shift_in(rem_q[k], GEN_LOW[k], din.data_byte, 8);
					end else if (is_tail) begin
						// five bits shifted, low three bits of the byte folded on top
						rem_q[k] <= shift_in(rem_q[k], GEN_LOW[k], din.data_byte, 5)
							^ {din.data_byte[2:0], 12'h000};
					end
				end
			end
		end
	end

	// snapshot takes the folded remainders: held byte into 11..4, high nibble into 3..0
	always_ff @(posedge clk) begin
		if (snap_load) begin
			snap_cnt_q <= cnt_c;
			for (int k = 0; k < NumSyndromes; k++)
				snap_q[k] <= rem_q[k] ^ {3'b000, held_q, din.data_byte[7:4]};
		end
	end

	// fixed evaluation matrix per syndrome
	for (genvar k = 0; k < NumSyndromes; k++) begin : g_eval
		localparam col_t COLS = eval_cols(k);
		always_comb begin
			syn_w[k] = '0;
			for (int j = 0; j < SymW; j++)
				if (snap_q[k][j]) syn_w[k] = syn_w[k] ^ COLS[j];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			emit_idx_q <= '0;
		end else if (snap_load) begin
			busy_q     <= 1'b1;
			emit_idx_q <= '0;
		end else if (out_load) begin
			if (emit_idx_q == snap_cnt_q - CntW'(1)) begin
				busy_q     <= 1'b0;
				emit_idx_q <= '0;
			end else begin
				emit_idx_q <= emit_idx_q + IdxW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (out_load) out_valid_q <= 1'b1;
		else if (dout.ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_idx_q  <= emit_idx_q;
			out_val_q  <= syn_w[emit_idx_q];
			out_last_q <= emit_idx_q == snap_cnt_q - CntW'(1);
		end
	end

	assign dout.valid          = out_valid_q;
	assign dout.syndrome_index = out_idx_q;
	assign dout.syndrome_value = out_val_q;
	assign dout.last_syndrome  = out_last_q;

	`ASSERT_NEXT(a_snap_busy, clk, arst_n, snap_load, busy_q, "snapshot load did not start emission")
	`ASSERT_CLK(a_idx_range, clk, arst_n, busy_q |-> emit_idx_q < snap_cnt_q, "emit index past count")
	`ASSERT_CLK(a_idle_idx, clk, arst_n, !busy_q |-> emit_idx_q == '0, "emit index not cleared when idle")
endmodule

// ===== tb/bch_syndrome_tb_pkg.sv =====
// syndrome predictor and scoreboard class for the bch syndrome testbench
`timescale 1ns / 1ps
package bch_syndrome_tb_pkg;
	import bchs_pkg::*;

	typedef struct packed {
		logic [4:0]  index;
		logic [14:0] value;
		logic        last;
	} syn_t;

	localparam logic [14:0] FEEDBACK [24] = '{
		15'h0003, 15'h0003, 15'h0423, 15'h0003, 15'h100B, 15'h0423, 15'h2AAB, 15'h0003,
		15'h0437, 15'h100B, 15'h08C7, 15'h0423, 15'h00CF, 15'h2AAB, 15'h7FFD, 15'h0003,
		15'h0729, 15'h0437, 15'h103D, 15'h100B, 15'h2FC1, 15'h08C7, 15'h0431, 15'h0423
	};

	class syndrome_scoreboard;
		logic [14:0] rem [24];
		int unsigned pos;
		logic [7:0]  held;
		int unsigned len_reg;
		int unsigned cnt_reg;
		syn_t        pending [$];
		int          errors;

		function new();
			len_reg = 4096;
			cnt_reg = 24;
			errors = 0;
			clear();
		endfunction

		function void clear();
			foreach (rem[k]) rem[k] = '0;
			pos = 0;
			held = '0;
		endfunction

		function void write_reg(logic [3:0] idx, logic [12:0] val);
			if (idx == REG_CODEWORD_BYTES) len_reg = val;
			else if (idx == REG_SYNDROME_COUNT) cnt_reg = val[4:0];
		endfunction

		static function logic [14:0] lfsr(logic [14:0] r, logic [14:0] g, logic [7:0] d,
			int n);
			logic [14:0] x;
			logic fb;
			x = r;
			for (int i = 0; i < n; i++) begin
				fb = x[14] ^ d[7-i];
				x = {x[13:0], 1'b0};
				if (fb) x ^= g;
			end
			return x;
		endfunction

		static function logic [14:0] times_alpha(logic [14:0] a);
			return {a[13:0], 1'b0} ^ (a[14] ? 15'h0003 : 15'h0000);
		endfunction

		// r(alpha^e) by horner-free power walk
		static function logic [14:0] evaluate(logic [14:0] r, int e);
			logic [14:0] p, acc;
			acc = '0;
			p = 15'h0001;
			for (int j = 0; j < 15; j++) begin
				if (r[j]) acc ^= p;
				for (int s = 0; s < e; s++) p = times_alpha(p);
			end
			return acc;
		endfunction

		function void note_byte(logic [7:0] d);
			int unsigned len, cnt;
			logic [14:0] t;
			syn_t s;
			len = len_reg < 3 ? 3 : (len_reg > 4096 ? 4096 : len_reg);
			cnt = cnt_reg < 1 ? 1 : (cnt_reg > 24 ? 24 : cnt_reg);
			if (pos < len - 3) begin
				foreach (rem[k]) rem[k] = lfsr(rem[k], FEEDBACK[k], d, 8);
				pos++;
			end else if (pos == len - 3) begin
				foreach (rem[k]) begin
					t = lfsr(rem[k], FEEDBACK[k], d, 5);
					rem[k] = t ^ {d[2:0], 12'h000};
				end
				pos++;
			end else if (pos == len - 2) begin
				held = d;
				pos++;
			end else begin
				foreach (rem[k]) rem[k] = rem[k] ^ {3'b000, held, d[7:4]};
				for (int k = 0; k < cnt; k++) begin
					s.index = 5'(k);
					s.value = evaluate(rem[k], k + 1);
					s.last = (k + 1 == cnt);
					pending.push_back(s);
				end
				clear();
			end
		endfunction

		task automatic report(string what);
			$display("mismatch: %s", what);
			errors++;
		endtask

		task automatic check(syn_t got);
			syn_t want;
			if (pending.size() == 0) begin
				report($sformatf("unexpected syndrome %0d", got.index));
				return;
			end
			want = pending.pop_front();
			if (got.index !== want.index)
				report($sformatf("index got %0d want %0d", got.index, want.index));
			if (got.value !== want.value)
				report($sformatf("syndrome %0d value got %h want %h", want.index,
					got.value, want.value));
			if (got.last !== want.last)
				report($sformatf("syndrome %0d last got %b want %b", want.index,
					got.last, want.last));
		endtask
	endclass
endpackage

// ===== tb/tb_top.sv =====
// top level testbench for the bch syndrome block
`timescale 1ns / 1ps
module tb_top;
	import bchs_pkg::*;
	import bch_syndrome_tb_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int unsigned cycles = 0;
	int unsigned bytes_sent = 0;
	syndrome_scoreboard sb;
	bit stall_free = 0;

	bchs_byte_if din ();
	bchs_syn_if  dout ();
	bchs_cfg_if  cfg ();

	bch_syndrome_gf2_15 dut (
		.clk(clk), .arst_n(arst_n), .din(din.sink), .dout(dout.source), .cfg(cfg.sink)
	);

	always #2 clk = ~clk;

	// cycle limit: far beyond the slowest legal run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("[bch_syndrome_gf2_15] ERROR");
			$finish;
		end
	end

	// sink side: random back pressure per result, checked on handshake
	initial begin
		int gap;
		dout.ready = 1'b0;
		wait (arst_n);
		forever begin
			gap = stall_free ? 0 : $urandom_range(0, 18);
			if (gap > 0) begin
				dout.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			dout.ready <= 1'b1;
			do @(posedge clk); while (!dout.valid);
			sb.check('{dout.syndrome_index, dout.syndrome_value, dout.last_syndrome});
		end
	end

	// one byte request, with a random lead gap
	task automatic send_byte(logic [7:0] d);
		int gap;
		gap = stall_free ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			din.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		din.valid <= 1'b1;
		din.data_byte <= d;
		do @(posedge clk); while (!din.ready);
		sb.note_byte(d);
		bytes_sent++;
	endtask

	task automatic stop_bytes();
		din.valid <= 1'b0;
	endtask

	// wait out every expected syndrome, then let the output settle
	task automatic drain();
		stop_bytes();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	// register write, only while idle; valid drops again after the handshake
	task automatic write_reg(cfg_reg_t idx, logic [12:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		do @(posedge clk); while (!cfg.ready);
		sb.write_reg(idx, val);
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	// one codeword of the given length; pattern 0 random, 1 zeros, 2 ones
	task automatic send_codeword(int n, int pattern);
		logic [7:0] d;
		for (int i = 0; i < n; i++) begin
			case (pattern)
				1: d = 8'h00;
				2: d = 8'hFF;
				default: d = 8'($urandom_range(0, 255));
			endcase
			send_byte(d);
		end
	endtask

	initial begin
		sb = new();
		din.valid = 1'b0;
		din.data_byte = '0;
		cfg.valid = 1'b0;
		cfg.index = REG_CODEWORD_BYTES;
		cfg.data = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: shortest codeword, extremes of the byte, all syndromes
		write_reg(REG_CODEWORD_BYTES, 13'd3);
		write_reg(REG_SYNDROME_COUNT, 13'd24);
		send_codeword(3, 1);
		send_codeword(3, 2);
		send_byte(8'h80); send_byte(8'h07); send_byte(8'h0F);
		drain();
		// length clamp below range, count clamp below and above range
		write_reg(REG_CODEWORD_BYTES, 13'd1);
		write_reg(REG_SYNDROME_COUNT, 13'd0);
		send_codeword(3, 0);
		drain();
		write_reg(REG_CODEWORD_BYTES, 13'd0);
		write_reg(REG_SYNDROME_COUNT, 13'd31);
		send_codeword(4, 2);
		drain();
		// unknown register index is ignored
		cfg.valid <= 1'b1;
		cfg.index <= 4'd9;
		cfg.data <= 13'h1FFF;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		@(posedge clk);
		// length shortened mid-codeword: the codeword ends at once
		write_reg(REG_CODEWORD_BYTES, 13'd10);
		write_reg(REG_SYNDROME_COUNT, 13'd5);
		send_codeword(7, 0);
		drain();
		write_reg(REG_CODEWORD_BYTES, 13'd4);
		send_codeword(1, 0);
		drain();

		// random phases: mostly short codewords under varied counts
		for (int ph = 0; ph < 8; ph++) begin
			write_reg(REG_CODEWORD_BYTES, 13'($urandom_range(3, 12)));
			write_reg(REG_SYNDROME_COUNT, 13'(ph == 0 ? 1 : $urandom_range(1, 24)));
			stall_free = (ph == 3);
			for (int c = 0; c < 6; c++) send_codeword(sb.len_reg, 0);
			drain();
		end
		stall_free = 0;
		write_reg(REG_CODEWORD_BYTES, 13'd5);
		write_reg(REG_SYNDROME_COUNT, 13'd24);
		for (int c = 0; c < 4; c++) send_codeword(5, 0);
		drain();

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("[bch_syndrome_gf2_15] OK");
		else
			$display("[bch_syndrome_gf2_15] ERROR");
		$finish;
	end
endmodule
